/* hdl/flmsb_pkg.sv */
// Package with the transfer types and codes of the shared-batching lock manager.
package flmsb_pkg;

   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [2:0] KIND_NOW      = 3'd0;
   localparam logic [2:0] KIND_QUEUED   = 3'd1;
   localparam logic [2:0] KIND_RELEASED = 3'd2;
   localparam logic [2:0] KIND_GRANT    = 3'd3;
   localparam logic [2:0] KIND_ERROR    = 3'd4;

   localparam logic [8:0] GROUP_MARK = 9'h100;

   typedef struct packed {
      logic       opcode;
      logic [7:0] trans_id;
      logic [3:0] object_id;
      logic       want_exclusive;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] grant_trans;
      logic [3:0] grant_object;
      logic       grant_exclusive;
      logic       last;
   } rsp_type;

endpackage

/* hdl/fifo_lock_manager_shared_batching_core.sv */
// Lock manager with per-object wait queues and batched shared waiters.
// An input transfer is registered, its object state and owner row are read, and it is then
// executed; a new input is taken only once the last one has finished. A shared group grant
// reads each group member from the group memory read port in turn and then closes the group.
// Reset: synchronous; a clearing pass then zeroes the object state and owner memories,
// one object per cycle, while no input is accepted.
module fifo_lock_manager_shared_batching_core #(
   parameter int NUM_OBJECTS = 16,
   parameter int NUM_TRANS   = 256,
   parameter int QUEUE_DEPTH = 16,
   parameter int GROUP_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  flmsb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output flmsb_pkg::rsp_type rsp_data
);

   localparam int OW   = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
   localparam int TW   = (NUM_TRANS > 1) ? $clog2(NUM_TRANS) : 1;
   localparam int HW   = $clog2(QUEUE_DEPTH);
   localparam int CW   = $clog2(QUEUE_DEPTH + 1);
   localparam int GW   = $clog2(GROUP_DEPTH + 1);
   localparam int GIW  = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
   localparam int OCW  = $clog2(GROUP_DEPTH + 1);
   localparam int SD   = NUM_OBJECTS * QUEUE_DEPTH;
   localparam int GD   = NUM_OBJECTS * GROUP_DEPTH;
   localparam int SAW  = (SD > 1) ? $clog2(SD) : 1;
   localparam int GAW  = (GD > 1) ? $clog2(GD) : 1;

   typedef struct packed {
      logic [OCW-1:0] cnt;
      logic           excl;
      logic [HW-1:0]  head;
      logic [CW-1:0]  wc;
      logic [GW-1:0]  gc;
   } st_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_BREAD, ST_BCHECK, ST_BEND
   } state_type;

   st_type             st_mem [NUM_OBJECTS];
   logic [NUM_TRANS-1:0] row_mem [NUM_OBJECTS];
   logic [8:0]         slot_mem [SD];
   logic [7:0]         grp_mem [GD];

   state_type            state_ff;
   logic [OW-1:0]        clr_ff;
   flmsb_pkg::req_type   req_ff;
   st_type               st_rd_ff, st_ff;
   logic [NUM_TRANS-1:0] row_rd_ff, row_ff;
   logic [8:0]           slot_rd_ff;
   logic [7:0]           grp_rd_ff;
   flmsb_pkg::rsp_type   pend_ff, rsp_ff;
   logic                 pend_valid_ff, rsp_valid_ff, was_ex_ff;
   logic [GW-1:0]        gidx_ff;

   logic                 accept, out_free, obj_ok, trans_ok, cand, rsp_load;
   logic [OW-1:0]        obj_idx, rd_obj;
   logic [TW-1:0]        t_idx;
   logic [CW:0]          tail_sum;
   logic [HW-1:0]        tail, head_in;
   logic [7:0]           t2;
   flmsb_pkg::rsp_type   ex_rsp;
   st_type               ex_st, st_wdata;
   logic [NUM_TRANS-1:0] ex_row, row_wdata;
   logic                 ex_burst, ex_st_we, ex_row_we, st_we, row_we, slot_we, grp_we;
   logic [8:0]           slot_wdata;
   logic [SAW-1:0]       slot_waddr, slot_raddr;
   logic [GAW-1:0]       grp_waddr, grp_raddr;
   logic [OW-1:0]        waddr;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rsp_load = (state_ff == ST_EXEC && out_free && !ex_burst) ||
                     (state_ff == ST_BCHECK && cand && pend_valid_ff && out_free) ||
                     (state_ff == ST_BEND && out_free);

   assign rd_obj   = OW'(req_data.object_id);
   assign obj_idx  = OW'(req_ff.object_id);
   assign t_idx    = TW'(req_ff.trans_id);
   assign obj_ok   = 32'(req_ff.object_id) < NUM_OBJECTS;
   assign trans_ok = 32'(req_ff.trans_id) < NUM_TRANS;
   assign t2       = slot_rd_ff[7:0];
   assign cand     = (32'(grp_rd_ff) < NUM_TRANS) && !row_ff[TW'(grp_rd_ff)];

   assign tail_sum = (CW+1)'(st_ff.head) + (CW+1)'(st_ff.wc);
   assign tail     = (32'(tail_sum) >= QUEUE_DEPTH) ?
                     HW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : HW'(tail_sum);
   assign head_in  = (32'(st_ff.head) == QUEUE_DEPTH - 1) ? '0 : HW'(st_ff.head + HW'(1));

   assign slot_waddr = SAW'(obj_idx) * SAW'(QUEUE_DEPTH) + SAW'(tail);
   assign slot_raddr = SAW'(obj_idx) * SAW'(QUEUE_DEPTH) + SAW'(st_rd_ff.head);
   assign grp_waddr  = GAW'(obj_idx) * GAW'(GROUP_DEPTH) + GAW'(GIW'(st_ff.gc));
   assign grp_raddr  = GAW'(obj_idx) * GAW'(GROUP_DEPTH) + GAW'(GIW'(gidx_ff));

   always_comb begin
      ex_rsp.kind            = flmsb_pkg::KIND_ERROR;
      ex_rsp.grant_trans     = req_ff.trans_id;
      ex_rsp.grant_object    = req_ff.object_id;
      ex_rsp.grant_exclusive = (req_ff.opcode == flmsb_pkg::OP_ACQUIRE) &&
                               req_ff.want_exclusive;
      ex_rsp.last            = 1'b1;
      ex_st      = st_ff;
      ex_row     = row_ff;
      ex_burst   = 1'b0;
      ex_st_we   = 1'b0;
      ex_row_we  = 1'b0;
      slot_we    = 1'b0;
      slot_wdata = {1'b0, req_ff.trans_id};
      grp_we     = 1'b0;
      if (obj_ok && trans_ok) begin
         if (req_ff.opcode == flmsb_pkg::OP_ACQUIRE) begin
            if (st_ff.cnt == '0 && st_ff.wc == '0) begin
               ex_st.cnt     = OCW'(1);
               ex_st.excl    = req_ff.want_exclusive;
               ex_row[t_idx] = 1'b1;
               ex_st_we      = 1'b1;
               ex_row_we     = 1'b1;
               ex_rsp.kind   = flmsb_pkg::KIND_NOW;
            end else if (req_ff.want_exclusive) begin
               if (32'(st_ff.wc) < QUEUE_DEPTH) begin
                  slot_we     = 1'b1;
                  ex_st.wc    = CW'(st_ff.wc + CW'(1));
                  ex_st_we    = 1'b1;
                  ex_rsp.kind = flmsb_pkg::KIND_QUEUED;
               end
            end else begin
               if (!(32'(st_ff.gc) >= GROUP_DEPTH ||
                     (st_ff.gc == '0 && 32'(st_ff.wc) >= QUEUE_DEPTH))) begin
                  if (st_ff.gc == '0) begin
                     slot_we    = 1'b1;
                     slot_wdata = flmsb_pkg::GROUP_MARK;
                     ex_st.wc   = CW'(st_ff.wc + CW'(1));
                  end
                  grp_we      = 1'b1;
                  ex_st.gc    = GW'(st_ff.gc + GW'(1));
                  ex_st_we    = 1'b1;
                  ex_rsp.kind = flmsb_pkg::KIND_QUEUED;
               end
            end
         end else begin
            if (row_ff[t_idx] && st_ff.cnt != '0) begin
               ex_row[t_idx]          = 1'b0;
               ex_st.cnt              = OCW'(st_ff.cnt - OCW'(1));
               ex_st_we               = 1'b1;
               ex_row_we              = 1'b1;
               ex_rsp.kind            = flmsb_pkg::KIND_RELEASED;
               ex_rsp.grant_exclusive = st_ff.excl;
               if (ex_st.cnt == '0) begin
                  ex_st.excl = 1'b0;
                  if (st_ff.wc != '0) begin
                     if (!slot_rd_ff[8]) begin
                        if (32'(t2) < NUM_TRANS) begin
                           ex_row[TW'(t2)] = 1'b1;
                        end
                        ex_st.cnt              = OCW'(1);
                        ex_st.excl             = 1'b1;
                        ex_st.head             = head_in;
                        ex_st.wc               = CW'(st_ff.wc - CW'(1));
                        ex_rsp.kind            = flmsb_pkg::KIND_GRANT;
                        ex_rsp.grant_trans     = t2;
                        ex_rsp.grant_exclusive = 1'b1;
                     end else begin
                        ex_burst  = 1'b1;
                        ex_st_we  = 1'b0;
                        ex_row_we = 1'b0;
                     end
                  end
               end
            end
         end
      end
   end

   always_comb begin
      st_we     = 1'b0;
      row_we    = 1'b0;
      st_wdata  = ex_st;
      row_wdata = ex_row;
      waddr     = obj_idx;
      unique case (state_ff)
         ST_CLEAR: begin
            st_we     = 1'b1;
            row_we    = 1'b1;
            st_wdata  = '0;
            row_wdata = '0;
            waddr     = clr_ff;
         end
         ST_EXEC: begin
            st_we  = out_free && ex_st_we;
            row_we = out_free && ex_row_we;
         end
         ST_BEND: begin
            st_we         = out_free;
            row_we        = out_free;
            st_wdata.cnt  = st_ff.cnt;
            st_wdata.excl = 1'b0;
            st_wdata.head = head_in;
            st_wdata.wc   = CW'(st_ff.wc - CW'(1));
            st_wdata.gc   = '0;
            row_wdata     = row_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[waddr] <= st_wdata;
      end
      if (row_we) begin
         row_mem[waddr] <= row_wdata;
      end
      if (accept) begin
         st_rd_ff  <= st_mem[rd_obj];
         row_rd_ff <= row_mem[rd_obj];
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we && state_ff == ST_EXEC && out_free) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      if (state_ff == ST_READ) begin
         slot_rd_ff <= slot_mem[slot_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (grp_we && state_ff == ST_EXEC && out_free) begin
         grp_mem[grp_waddr] <= req_ff.trans_id;
      end
      if (state_ff == ST_BREAD) begin
         grp_rd_ff <= grp_mem[grp_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= OW'(clr_ff + OW'(1));
               if (32'(clr_ff) == NUM_OBJECTS - 1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  req_ff   <= req_data;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               st_ff    <= st_rd_ff;
               row_ff   <= row_rd_ff;
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               if (out_free) begin
                  if (ex_burst) begin
                     st_ff         <= ex_st;
                     row_ff        <= ex_row;
                     was_ex_ff     <= st_ff.excl;
                     gidx_ff       <= '0;
                     pend_valid_ff <= 1'b0;
                     state_ff      <= (st_ff.gc == '0) ? ST_BEND : ST_BREAD;
                  end else begin
                     rsp_ff   <= ex_rsp;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_BREAD: begin
               state_ff <= ST_BCHECK;
            end
            ST_BCHECK: begin
               if (!(cand && pend_valid_ff && !out_free)) begin
                  if (cand) begin
                     if (pend_valid_ff) begin
                        rsp_ff <= pend_ff;
                     end
                     pend_ff.kind            <= flmsb_pkg::KIND_GRANT;
                     pend_ff.grant_trans     <= grp_rd_ff;
                     pend_ff.grant_object    <= req_ff.object_id;
                     pend_ff.grant_exclusive <= 1'b0;
                     pend_ff.last            <= 1'b0;
                     pend_valid_ff           <= 1'b1;
                     row_ff[TW'(grp_rd_ff)]  <= 1'b1;
                     st_ff.cnt               <= OCW'(st_ff.cnt + OCW'(1));
                  end
                  gidx_ff  <= GW'(gidx_ff + GW'(1));
                  state_ff <= (GW'(gidx_ff + GW'(1)) == st_ff.gc) ? ST_BEND : ST_BREAD;
               end
            end
            ST_BEND: begin
               if (out_free) begin
                  if (pend_valid_ff) begin
                     rsp_ff <= '{kind: pend_ff.kind, grant_trans: pend_ff.grant_trans,
                                 grant_object: pend_ff.grant_object,
                                 grant_exclusive: pend_ff.grant_exclusive, last: 1'b1};
                  end else begin
                     rsp_ff <= '{kind: flmsb_pkg::KIND_RELEASED,
                                 grant_trans: req_ff.trans_id,
                                 grant_object: req_ff.object_id,
                                 grant_exclusive: was_ex_ff, last: 1'b1};
                  end
                  pend_valid_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_owner_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC || state_ff == ST_BEND) |-> (32'(st_ff.cnt) <= GROUP_DEPTH))
      else $error("owner count exceeds group depth");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> (32'(st_ff.wc) <= QUEUE_DEPTH))
      else $error("wait queue count exceeds queue depth");

   a_burst_has_queue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BEND) |-> (st_ff.wc != '0 && st_ff.cnt == OCW'($countones(row_ff))))
      else $error("group grant without a queued slot or with inconsistent owner count");

   a_pend_only_in_burst: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending grant left after the burst ended");
`endif

endmodule

/* bench/fifo_lock_manager_shared_batching_core_tb.sv */
// Testbench that checks the shared-batching lock manager against a predictor of its lock state.
module fifo_lock_manager_shared_batching_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_OBJ     = 16;
   localparam int Q_DEPTH   = 16;
   localparam int G_DEPTH   = 16;
   localparam int EXP_DEPTH = 64;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   flmsb_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   flmsb_pkg::rsp_type rsp_data;

   fifo_lock_manager_shared_batching_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predicted lock state.
   int        holders[N_OBJ];
   bit        held_excl[N_OBJ];
   bit        holds[N_OBJ][256];
   logic [8:0] queue_slot[N_OBJ][Q_DEPTH];
   int        q_head[N_OBJ];
   int        q_len[N_OBJ];
   logic [7:0] readers[N_OBJ][G_DEPTH];
   int        readers_len[N_OBJ];

   flmsb_pkg::rsp_type exp_mem[EXP_DEPTH];
   int                 exp_wr = 0;
   int                 exp_rd = 0;
   int                 errors = 0;

   function automatic flmsb_pkg::rsp_type mk(logic [2:0] k, logic [7:0] t, logic [3:0] o,
                                             logic e);
      flmsb_pkg::rsp_type r;
      r.kind = k; r.grant_trans = t; r.grant_object = o; r.grant_exclusive = e;
      r.last = 1'b0;
      return r;
   endfunction

   function automatic void note_expected(flmsb_pkg::rsp_type r);
      exp_mem[exp_wr % EXP_DEPTH] = r;
      exp_wr++;
   endfunction

   function automatic void enqueue_slot(int o, logic [8:0] v);
      queue_slot[o][(q_head[o] + q_len[o]) % Q_DEPTH] = v;
      q_len[o]++;
   endfunction

   function automatic void predict_locks(flmsb_pkg::req_type r);
      int o;
      int t;
      int first;
      logic [8:0] s;
      bit was_ex;
      o = r.object_id;
      t = r.trans_id;
      first = exp_wr;
      if (r.opcode == flmsb_pkg::OP_ACQUIRE) begin
         if (holders[o] == 0 && q_len[o] == 0) begin
            holders[o] = 1; held_excl[o] = r.want_exclusive; holds[o][t] = 1;
            note_expected(mk(flmsb_pkg::KIND_NOW, r.trans_id, r.object_id, r.want_exclusive));
         end else if (r.want_exclusive) begin
            if (q_len[o] >= Q_DEPTH) begin
               note_expected(mk(flmsb_pkg::KIND_ERROR, r.trans_id, r.object_id, 1'b1));
            end else begin
               enqueue_slot(o, {1'b0, r.trans_id});
               note_expected(mk(flmsb_pkg::KIND_QUEUED, r.trans_id, r.object_id, 1'b1));
            end
         end else if (readers_len[o] >= G_DEPTH ||
                      (readers_len[o] == 0 && q_len[o] >= Q_DEPTH)) begin
            note_expected(mk(flmsb_pkg::KIND_ERROR, r.trans_id, r.object_id, 1'b0));
         end else begin
            if (readers_len[o] == 0) enqueue_slot(o, flmsb_pkg::GROUP_MARK);
            readers[o][readers_len[o]] = r.trans_id;
            readers_len[o]++;
            note_expected(mk(flmsb_pkg::KIND_QUEUED, r.trans_id, r.object_id, 1'b0));
         end
      end else begin
         was_ex = held_excl[o];
         if (!holds[o][t] || holders[o] == 0) begin
            note_expected(mk(flmsb_pkg::KIND_ERROR, r.trans_id, r.object_id, 1'b0));
         end else begin
            holds[o][t] = 0;
            holders[o]--;
            if (holders[o] == 0) begin
               held_excl[o] = 0;
               if (q_len[o] != 0) begin
                  s = queue_slot[o][q_head[o]];
                  if (s != flmsb_pkg::GROUP_MARK) begin
                     holds[o][s[7:0]] = 1; holders[o] = 1; held_excl[o] = 1;
                     note_expected(mk(flmsb_pkg::KIND_GRANT, s[7:0], r.object_id, 1'b1));
                  end else begin
                     for (int i = 0; i < readers_len[o]; i++) begin
                        if (!holds[o][readers[o][i]]) begin
                           holds[o][readers[o][i]] = 1;
                           holders[o]++;
                           note_expected(mk(flmsb_pkg::KIND_GRANT, readers[o][i],
                                            r.object_id, 1'b0));
                        end
                     end
                     held_excl[o] = 0;
                     readers_len[o] = 0;
                  end
                  q_head[o] = (q_head[o] + 1) % Q_DEPTH;
                  q_len[o]--;
               end
            end
            if (exp_wr == first) begin
               note_expected(mk(flmsb_pkg::KIND_RELEASED, r.trans_id, r.object_id, was_ex));
            end
         end
      end
      exp_mem[(exp_wr - 1) % EXP_DEPTH].last = 1'b1;
   endfunction

   task automatic send_item(logic op, logic [7:0] t, logic [3:0] o, logic e);
      flmsb_pkg::req_type r;
      int gap;
      r.opcode = op; r.trans_id = t; r.object_id = o; r.want_exclusive = e;
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_locks(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (exp_wr == exp_rd) begin
               $error("unexpected transfer kind=%0d", rsp_data.kind);
               errors++;
            end else begin
               flmsb_pkg::rsp_type x;
               x = exp_mem[exp_rd % EXP_DEPTH];
               exp_rd++;
               if (rsp_data.kind != x.kind) begin
                  $error("kind exp %0d got %0d", x.kind, rsp_data.kind); errors++;
               end
               if (rsp_data.grant_trans != x.grant_trans) begin
                  $error("grant_trans exp %0d got %0d", x.grant_trans, rsp_data.grant_trans);
                  errors++;
               end
               if (rsp_data.grant_object != x.grant_object) begin
                  $error("grant_object exp %0d got %0d", x.grant_object,
                         rsp_data.grant_object);
                  errors++;
               end
               if (rsp_data.grant_exclusive != x.grant_exclusive) begin
                  $error("grant_exclusive exp %0d got %0d", x.grant_exclusive,
                         rsp_data.grant_exclusive);
                  errors++;
               end
               if (rsp_data.last != x.last) begin
                  $error("last exp %0d got %0d", x.last, rsp_data.last); errors++;
               end
            end
         end
      end
   end

   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         stall_left <= $urandom_range(0, 7);
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic test_exclusive_chain();
      send_item(flmsb_pkg::OP_ACQUIRE, 8'd0, 4'd0, 1'b1);
      send_item(flmsb_pkg::OP_ACQUIRE, 8'd255, 4'd0, 1'b1);
      send_item(flmsb_pkg::OP_ACQUIRE, 8'd1, 4'd0, 1'b0);
      send_item(flmsb_pkg::OP_RELEASE, 8'd0, 4'd0, 1'b0);
      send_item(flmsb_pkg::OP_RELEASE, 8'd255, 4'd0, 1'b1);
      send_item(flmsb_pkg::OP_RELEASE, 8'd1, 4'd0, 1'b0);
      send_item(flmsb_pkg::OP_RELEASE, 8'd7, 4'd15, 1'b1);
   endtask

   task automatic test_shared_group();
      send_item(flmsb_pkg::OP_ACQUIRE, 8'd10, 4'd15, 1'b1);
      send_item(flmsb_pkg::OP_ACQUIRE, 8'd11, 4'd15, 1'b0);
      send_item(flmsb_pkg::OP_ACQUIRE, 8'd12, 4'd15, 1'b0);
      send_item(flmsb_pkg::OP_ACQUIRE, 8'd11, 4'd15, 1'b0);
      send_item(flmsb_pkg::OP_ACQUIRE, 8'd10, 4'd15, 1'b0);
      send_item(flmsb_pkg::OP_RELEASE, 8'd10, 4'd15, 1'b0);
      send_item(flmsb_pkg::OP_RELEASE, 8'd11, 4'd15, 1'b0);
      send_item(flmsb_pkg::OP_RELEASE, 8'd12, 4'd15, 1'b0);
      send_item(flmsb_pkg::OP_RELEASE, 8'd10, 4'd15, 1'b0);
   endtask

   task automatic test_overflow();
      send_item(flmsb_pkg::OP_ACQUIRE, 8'd100, 4'd5, 1'b1);
      for (int i = 0; i < 17; i++) send_item(flmsb_pkg::OP_ACQUIRE, 8'(i), 4'd5, 1'b0);
      for (int i = 0; i < 16; i++) begin
         send_item(flmsb_pkg::OP_ACQUIRE, 8'(200 + i), 4'd5, 1'b1);
      end
      send_item(flmsb_pkg::OP_RELEASE, 8'd100, 4'd5, 1'b0);
      for (int i = 0; i < 16; i++) send_item(flmsb_pkg::OP_RELEASE, 8'(i), 4'd5, 1'b0);
      for (int i = 0; i < 15; i++) begin
         send_item(flmsb_pkg::OP_RELEASE, 8'(200 + i), 4'd5, 1'b0);
      end
      drain();
   endtask

   task automatic test_random();
      int o;
      for (int n = 0; n < 320; n++) begin
         o = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 2);
         if ($urandom_range(0, 1)) begin
            send_item(flmsb_pkg::OP_ACQUIRE, 8'($urandom_range(0, 15)
                      | ($urandom_range(0, 1) << 7) | ($urandom_range(0, 7) << 4)), 4'(o),
                      1'($urandom_range(0, 2) == 0));
         end else begin
            send_item(flmsb_pkg::OP_RELEASE, 8'($urandom_range(0, 15)
                      | ($urandom_range(0, 1) << 7) | ($urandom_range(0, 7) << 4)), 4'(o),
                      1'($urandom()));
         end
         if (n == 200) drain();
      end
   endtask

   initial begin
      for (int o = 0; o < N_OBJ; o++) begin
         holders[o] = 0; held_excl[o] = 0; q_head[o] = 0; q_len[o] = 0;
         readers_len[o] = 0;
         for (int t = 0; t < 256; t++) holds[o][t] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_exclusive_chain();
      test_shared_group();
      test_overflow();
      test_random();
      drain();
      if (errors == 0 && exp_wr == exp_rd) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
